### src/assert_macros.svh
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert an implication each clock, disabled in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// assert an implication in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### src/aescm_pkg.sv
// Package: AES constants, S-box and helper functions for the CMAC engine
package aescm_pkg;
    localparam int unsigned BlockW = 128;
    localparam int unsigned CntW   = 5;
    localparam logic [7:0]  RbConst  = 8'h87;
    localparam logic [7:0]  PadConst = 8'h80;
    localparam logic [7:0]  PolyConst = 8'h1b;
    localparam logic [7:0]  RconFirst = 8'h01;
    localparam logic [7:0]  RconLast  = 8'h36;
    localparam logic [0:0]  RegKeyHigh = 1'b0;
    localparam logic [0:0]  RegKeyLow  = 1'b1;

    typedef logic [BlockW-1:0] t_block;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] r;
        unique case (x)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r=8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? PolyConst : 8'h00);
    endfunction

    // byte i of a block, byte 0 at the top
    function automatic logic [7:0] get_byte(input t_block b, input int i);
        return b[BlockW-1-8*i -: 8];
    endfunction

    // CMAC subkey doubling
    function automatic t_block cmac_dbl(input t_block b);
        return {b[BlockW-2:0], 1'b0} ^ (b[BlockW-1] ? {120'd0, RbConst} : '0);
    endfunction
endpackage

### src/aescm_if.sv
// Valid/ready channel interfaces for the CMAC engine
interface aescm_blk_if (input logic i_clk);
    logic        valid;
    logic        ready;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic [4:0]  byte_count;
    logic        final_block;
    modport source (output valid, block_high, block_low, byte_count, final_block, input ready);
    modport sink   (input valid, block_high, block_low, byte_count, final_block, output ready);
endinterface

interface aescm_tag_if (input logic i_clk);
    logic        valid;
    logic        ready;
    logic [63:0] tag_high;
    logic [63:0] tag_low;
    modport source (output valid, tag_high, tag_low, input ready);
    modport sink   (input valid, tag_high, tag_low, output ready);
endinterface

interface aescm_cfg_if (input logic i_clk);
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/aescm_round.sv
// One AES-128 round plus the matching key-schedule step
module aescm_round (
    input  aescm_pkg::t_block i_state,
    input  aescm_pkg::t_block i_rkey,
    input  logic [7:0]        i_rcon,
    input  logic              i_last,
    output aescm_pkg::t_block o_state,
    output aescm_pkg::t_block o_rkey
);
    logic [7:0] w_rk  [16];
    logic [7:0] w_nrk [16];
    logic [7:0] w_s   [16];
    logic [7:0] w_t   [16];
    logic [7:0] w_m   [16];
    logic [7:0] w_tk  [4];

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            w_rk[i] = aescm_pkg::get_byte(i_rkey, i);
            w_s[i]  = aescm_pkg::get_byte(i_state, i);
        end
        w_tk[0] = aescm_pkg::sbox(w_rk[13]) ^ i_rcon;
        w_tk[1] = aescm_pkg::sbox(w_rk[14]);
        w_tk[2] = aescm_pkg::sbox(w_rk[15]);
        w_tk[3] = aescm_pkg::sbox(w_rk[12]);
        for (int i = 0; i < 4; i++) w_nrk[i] = w_rk[i] ^ w_tk[i];
        for (int i = 4; i < 16; i++) w_nrk[i] = w_rk[i] ^ w_nrk[i-4];
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                w_t[c*4+i] = aescm_pkg::sbox(w_s[((c+i) & 3)*4 + i]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                w_m[c*4+i] = w_t[c*4+i] ^ w_t[c*4] ^ w_t[c*4+1] ^ w_t[c*4+2]
                    ^ w_t[c*4+3]
                    ^ aescm_pkg::xtime(w_t[c*4+i] ^ w_t[c*4 + ((i+1) & 3)]);
            end
        end
        for (int i = 0; i < 16; i++) begin
            o_rkey[127-8*i -: 8]  = w_nrk[i];
            o_state[127-8*i -: 8] = (i_last ? w_t[i] : w_m[i]) ^ w_nrk[i];
        end
    end
endmodule

### src/aes128_cmac_engine_unit.sv
// AES-128 CMAC engine top level.
// Takes 16-byte message beats and returns the CMAC tag after the final beat.
// Each beat runs one AES-128 encryption through a single shared round unit,
// one round per cycle. After a beat is accepted the input stays not ready through
// load, the 10 rounds and finish, so a new beat is taken only once the last is
// through. The tag is offered from the cycle after finish and held until taken.
// The first beat after reset or after a key write first derives subkeys K1/K2
// with one extra encryption. Key writes only while idle; a pending key write
// holds off the message input.
module aes128_cmac_engine_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    aescm_blk_if.sink   i_blk,
    aescm_tag_if.source o_tag,
    aescm_cfg_if.sink   i_cfg
);
    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StSub  = 3'd1;
    localparam logic [2:0] StLoad = 3'd2;
    localparam logic [2:0] StRnd  = 3'd3;
    localparam logic [2:0] StDone = 3'd4;
    localparam logic [2:0] StOut  = 3'd5;

    logic [2:0]        r_st, n_st;
    logic [63:0]       r_key_hi, r_key_lo;
    aescm_pkg::t_block r_chain, r_k1, r_k2, r_s, r_rk, r_msg, r_tag;
    logic              r_kv, r_sub, r_fin;
    logic [4:0]        r_cnt;
    logic [3:0]        r_rnd;
    logic [7:0]        r_rcon;
    aescm_pkg::t_block w_ns, w_nrk, w_in, w_pad, w_key;
    aescm_pkg::t_block w_l;

    aescm_round u_round (
        .i_state (r_s), .i_rkey (r_rk), .i_rcon (r_rcon),
        .i_last  (r_rnd == 4'd10),
        .o_state (w_ns), .o_rkey (w_nrk)
    );

    assign i_blk.ready = (r_st == StIdle) && !i_cfg.valid;
    assign i_cfg.ready = (r_st == StIdle);
    assign o_tag.valid = (r_st == StOut);
    assign o_tag.tag_high = r_tag[127:64];
    assign o_tag.tag_low  = r_tag[63:0];
    assign w_key = {r_key_hi, r_key_lo};
    assign w_l   = aescm_pkg::cmac_dbl(w_ns);

    always_comb begin
        w_pad = r_msg;
        if (r_cnt < 5'd16) begin
            for (int i = 0; i < 16; i++) begin
                if (5'(i) > r_cnt) w_pad[127-8*i -: 8] = 8'h00;
                else if (5'(i) == r_cnt) w_pad[127-8*i -: 8] = aescm_pkg::PadConst;
            end
        end
        if (!r_fin) w_in = r_chain ^ r_msg;
        else if (r_cnt >= 5'd16) w_in = r_chain ^ r_msg ^ r_k1;
        else w_in = r_chain ^ w_pad ^ r_k2;
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            StIdle: if (i_blk.valid && i_blk.ready) n_st = r_kv ? StLoad : StSub;
            StSub:  n_st = StRnd;
            StLoad: n_st = StRnd;
            StRnd:  if (r_rnd == 4'd10) n_st = StDone;
            StDone: n_st = r_sub ? StLoad : (r_fin ? StOut : StIdle);
            StOut:  if (o_tag.ready) n_st = StIdle;
            default: n_st = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= StIdle; r_kv <= 1'b0; r_key_hi <= '0; r_key_lo <= '0;
            r_chain <= '0; r_rnd <= '0; r_sub <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == aescm_pkg::RegKeyHigh) r_key_hi <= i_cfg.data;
                else r_key_lo <= i_cfg.data;
                r_kv <= 1'b0;
                r_chain <= '0;
            end
            unique case (r_st)
                StIdle: if (i_blk.valid && i_blk.ready) begin
                    r_msg <= {i_blk.block_high, i_blk.block_low};
                    r_cnt <= i_blk.byte_count > 5'd16 ? 5'd16 : i_blk.byte_count;
                    r_fin <= i_blk.final_block;
                end
                StSub: begin
                    r_s <= w_key; r_rk <= w_key; r_sub <= 1'b1;
                    r_rnd <= 4'd1; r_rcon <= aescm_pkg::RconFirst;
                end
                StLoad: begin
                    r_s <= w_in ^ w_key; r_rk <= w_key; r_sub <= 1'b0;
                    r_rnd <= 4'd1; r_rcon <= aescm_pkg::RconFirst;
                end
                StRnd: begin
                    r_s <= w_ns; r_rk <= w_nrk;
                    r_rnd <= r_rnd + 4'd1;
                    r_rcon <= aescm_pkg::xtime(r_rcon);
                    if (r_rnd == 4'd10) begin
                        if (r_sub) begin
                            r_k1 <= w_l;
                            r_k2 <= aescm_pkg::cmac_dbl(w_l);
                            r_kv <= 1'b1;
                        end else if (r_fin) begin
                            r_tag <= w_ns; r_chain <= '0;
                        end else begin
                            r_chain <= w_ns;
                        end
                    end
                end
                StDone, StOut: ;
                default: ;
            endcase
        end
    end
endmodule

### src/aescm_checker.sv
// Port-level checker for the CMAC engine, bound to the top level
`include "assert_macros.svh"
module aescm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic blk_valid,
    input logic blk_ready,
    input logic tag_valid,
    input logic tag_ready,
    input logic cfg_ready,
    input logic [63:0] tag_high
);
    `ASSERT_IMPL(a_busy_no_tag, i_clk, i_rst_n, blk_ready, !tag_valid)
    `ASSERT_IMPL(a_blk_implies_cfg, i_clk, i_rst_n, blk_ready, cfg_ready)
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, blk_valid && blk_ready, !blk_ready)
    `ASSERT_NEXT(a_tag_hold, i_clk, i_rst_n, tag_valid && !tag_ready,
        tag_valid && $stable(tag_high))
endmodule

bind aes128_cmac_engine_unit aescm_checker u_chk (
    .i_clk (i_clk), .i_rst_n (i_rst_n),
    .blk_valid (i_blk.valid), .blk_ready (i_blk.ready),
    .tag_valid (o_tag.valid), .tag_ready (o_tag.ready),
    .cfg_ready (i_cfg.ready), .tag_high (o_tag.tag_high)
);

### tb/aes128_cmac_engine_unit_tb.sv
// Testbench for the AES-128 CMAC engine: directed vectors, random messages, tag checks
`timescale 1ns / 100ps

module aes128_cmac_engine_unit_tb;

    localparam int unsigned WatchdogLimit = 4000;
    localparam int unsigned DrainCycles   = 60;
    localparam int unsigned RandomItems   = 1100;

    typedef struct {
        logic [63:0] bh;
        logic [63:0] bl;
        logic [4:0]  cnt;
        logic        fin;
        logic        typed;
        logic [127:0] tag;
    } t_row;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
    } t_tag;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    aescm_blk_if blk_if (i_clk);
    aescm_tag_if tag_if (i_clk);
    aescm_cfg_if cfg_if (i_clk);

    aes128_cmac_engine_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_blk   (blk_if),
        .o_tag   (tag_if),
        .i_cfg   (cfg_if)
    );

    always #10 i_clk = ~i_clk;

    logic [7:0] sb [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // predictor state
    logic [127:0] cmac_key;
    logic [127:0] running_x;
    logic [127:0] k1_val;
    logic [127:0] k2_val;
    logic         k_ready;

    t_tag tag_queue[$];
    int   send_idle;
    int   recv_idle;
    int   n_fail;
    int   n_tags;
    int   n_blocks;
    int   quiet_cycles;

    function automatic logic [7:0] gmul2(logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] aes_encrypt(logic [127:0] k, logic [127:0] p);
        logic [7:0] s[16], rk[16], t[16], w[4];
        logic [7:0] rcon, a0, a1, a2, a3, al;
        logic [127:0] r;
        rcon = 8'h01;
        for (int i = 0; i < 16; i++) begin
            rk[i] = k[127-8*i -: 8];
            s[i] = p[127-8*i -: 8] ^ rk[i];
        end
        for (int rnd = 1; rnd <= 10; rnd++) begin
            w[0] = sb[rk[13]] ^ rcon;
            w[1] = sb[rk[14]];
            w[2] = sb[rk[15]];
            w[3] = sb[rk[12]];
            for (int i = 0; i < 16; i++) rk[i] = rk[i] ^ (i < 4 ? w[i] : rk[i-4]);
            rcon = gmul2(rcon);
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++) t[c*4+i] = sb[s[((c+i)&3)*4+i]];
            for (int c = 0; c < 4; c++) begin
                if (rnd < 10) begin
                    a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    t[c*4]   = a0 ^ al ^ gmul2(a0 ^ a1);
                    t[c*4+1] = a1 ^ al ^ gmul2(a1 ^ a2);
                    t[c*4+2] = a2 ^ al ^ gmul2(a2 ^ a3);
                    t[c*4+3] = a3 ^ al ^ gmul2(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[i];
        end
        for (int i = 0; i < 16; i++) r[127-8*i -: 8] = s[i];
        return r;
    endfunction

    function automatic logic [127:0] gf_dbl128(logic [127:0] b);
        return {b[126:0], 1'b0} ^ (b[127] ? 128'h87 : 128'h0);
    endfunction

    // returns 1 and the tag when the beat closes a message
    function automatic bit cmac_absorb(logic [63:0] bh, logic [63:0] bl, logic [4:0] cnt,
                                       logic fin, output logic [127:0] tag);
        logic [127:0] m;
        int n;
        if (!k_ready) begin
            k1_val = gf_dbl128(aes_encrypt(cmac_key, 128'h0));
            k2_val = gf_dbl128(k1_val);
            k_ready = 1'b1;
        end
        m = {bh, bl};
        if (!fin) begin
            running_x = aes_encrypt(cmac_key, running_x ^ m);
            return 0;
        end
        n = (cnt > 16) ? 16 : int'(cnt);
        if (n == 16) begin
            m = m ^ k1_val;
        end else begin
            for (int i = n; i < 16; i++)
                m[127-8*i -: 8] = (i == n) ? aescm_pkg::PadConst : 8'h00;
            m = m ^ k2_val;
        end
        tag = aes_encrypt(cmac_key, running_x ^ m);
        running_x = '0;
        return 1;
    endfunction

    task automatic cfg_write(logic [0:0] idx, logic [63:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        if (idx == aescm_pkg::RegKeyHigh) cmac_key[127:64] = data;
        else cmac_key[63:0] = data;
        k_ready = 1'b0;
        running_x = '0;
    endtask

    task automatic wait_idle();
        blk_if.valid <= 1'b0;
        while (tag_queue.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic load_key(logic [63:0] hi, logic [63:0] lo);
        wait_idle();
        cfg_write(aescm_pkg::RegKeyHigh, hi);
        cfg_write(aescm_pkg::RegKeyLow, lo);
    endtask

    task automatic send_beat(logic [63:0] bh, logic [63:0] bl, logic [4:0] cnt, logic fin,
                             logic typed = 1'b0, logic [127:0] typed_tag = '0);
        logic [127:0] tag;
        t_tag e;
        if ($urandom_range(99) < send_idle) begin
            blk_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
        blk_if.valid       <= 1'b1;
        blk_if.block_high  <= bh;
        blk_if.block_low   <= bl;
        blk_if.byte_count  <= cnt;
        blk_if.final_block <= fin;
        do @(posedge i_clk); while (!blk_if.ready);
        n_blocks++;
        if (cmac_absorb(bh, bl, cnt, fin, tag)) begin
            if (typed) tag = typed_tag;
            e.hi = tag[127:64];
            e.lo = tag[63:0];
            tag_queue.push_back(e);
        end
    endtask

    task automatic random_phase(int items);
        int done;
        int nblk;
        logic [4:0] c;
        done = 0;
        while (done < items) begin
            nblk = ($urandom_range(9) == 0) ? $urandom_range(8, 5) : $urandom_range(3, 1);
            for (int b = 0; b < nblk; b++) begin
                if (b < nblk - 1) begin
                    c = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'd16;
                end else begin
                    case ($urandom_range(5))
                        0: c = 5'd16;
                        1: c = 5'd0;
                        2: c = 5'($urandom_range(31, 17));
                        default: c = 5'($urandom_range(15, 1));
                    endcase
                end
                send_beat({$urandom, $urandom}, {$urandom, $urandom}, c, b == nblk - 1);
            end
            done += nblk;
        end
    endtask

    // tag checker
    always @(posedge i_clk) begin
        t_tag e;
        if (i_rst_n && tag_if.valid && tag_if.ready) begin
            n_tags++;
            if (tag_queue.size() == 0) begin
                $error("unexpected tag %h_%h", tag_if.tag_high, tag_if.tag_low);
                n_fail++;
            end else begin
                e = tag_queue.pop_front();
                if (tag_if.tag_high !== e.hi) begin
                    $error("tag_high: expected %h, actual %h", e.hi, tag_if.tag_high);
                    n_fail++;
                end
                if (tag_if.tag_low !== e.lo) begin
                    $error("tag_low: expected %h, actual %h", e.lo, tag_if.tag_low);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tag_if.ready <= 1'b0;
        end else begin
            tag_if.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (blk_if.valid && blk_if.ready) || (tag_if.valid && tag_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchdogLimit) begin
            $display("timeout after %0d idle cycles", quiet_cycles);
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    t_row dir_rows[] = '{
        '{64'h0, 64'h0, 5'd0, 1'b1, 1'b1, 128'hbb1d6929e95937287fa37d129b756746},
        '{64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 1'b1, 1'b1,
          128'h070a16b46b4d4144f79bdd9dd04a287c},
        '{64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 1'b0, 1'b0, 128'h0},
        '{64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51, 5'd16, 1'b0, 1'b0, 128'h0},
        '{64'h30c81c46a35ce411, 64'hffffffffffffffff, 5'd8, 1'b1, 1'b1,
          128'hdfa66747de9ae63030ca32611497c827},
        '{64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 1'b0, 1'b0, 128'h0},
        '{64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51, 5'd0, 1'b0, 1'b0, 128'h0},
        '{64'h30c81c46a35ce411, 64'he5fbc1191a0a52ef, 5'd31, 1'b0, 1'b0, 128'h0},
        '{64'hf69f2445df4f9b17, 64'had2b417be66c3710, 5'd16, 1'b1, 1'b1,
          128'h51f0bebf7e3b9d92fc49741779363cfe},
        '{64'hffffffffffffffff, 64'hffffffffffffffff, 5'd16, 1'b1, 1'b0, 128'h0},
        '{64'hffffffffffffffff, 64'hffffffffffffffff, 5'd15, 1'b1, 1'b0, 128'h0},
        '{64'hffffffffffffffff, 64'hffffffffffffffff, 5'd1, 1'b1, 1'b0, 128'h0},
        '{64'hffffffffffffffff, 64'hffffffffffffffff, 5'd0, 1'b1, 1'b0, 128'h0},
        '{64'h0, 64'h0, 5'd16, 1'b1, 1'b0, 128'h0},
        '{64'h0123456789abcdef, 64'hfedcba9876543210, 5'd17, 1'b1, 1'b0, 128'h0},
        '{64'h0123456789abcdef, 64'hfedcba9876543210, 5'd31, 1'b1, 1'b0, 128'h0},
        '{64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 5'd0, 1'b0, 1'b0, 128'h0},
        '{64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 5'd7, 1'b1, 1'b0, 128'h0},
        // left open: the next key write drops it
        '{64'h1111111111111111, 64'h2222222222222222, 5'd16, 1'b0, 1'b0, 128'h0}
    };

    initial begin
        blk_if.valid = 1'b0;
        blk_if.block_high = '0;
        blk_if.block_low = '0;
        blk_if.byte_count = '0;
        blk_if.final_block = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = aescm_pkg::RegKeyHigh;
        cfg_if.data = '0;
        tag_if.ready = 1'b0;
        cmac_key = '0;
        running_x = '0;
        k1_val = '0;
        k2_val = '0;
        k_ready = 1'b0;
        n_fail = 0;
        n_tags = 0;
        n_blocks = 0;
        quiet_cycles = 0;
        send_idle = 14;
        recv_idle = 68;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset key (all zero) first, then the standard test key
        send_beat({$urandom, $urandom}, {$urandom, $urandom}, 5'd5, 1'b1);
        load_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
        foreach (dir_rows[i])
            send_beat(dir_rows[i].bh, dir_rows[i].bl, dir_rows[i].cnt, dir_rows[i].fin,
                      dir_rows[i].typed, dir_rows[i].tag);

        for (int mode = 0; mode < 3; mode++) begin
            send_idle = (mode == 0) ? 14 : (mode == 1) ? 68 : 0;
            recv_idle = (mode == 0) ? 68 : (mode == 1) ? 14 : 0;
            load_key(64'h0, 64'h0);
            random_phase(RandomItems / 9);
            load_key(64'hffffffffffffffff, 64'hffffffffffffffff);
            random_phase(RandomItems / 9);
            load_key({$urandom, $urandom}, {$urandom, $urandom});
            random_phase(RandomItems / 9);
        end
        blk_if.valid <= 1'b0;
        wait_idle();

        $display("covered %0d message beats and %0d tags over 11 key settings and 3 idle profiles",
                 n_blocks, n_tags);
        if (n_fail == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", n_fail);
            $display("tb: failure");
        end
        $finish;
    end
endmodule

### aes128_cmac_engine_unit.f
+incdir+src
src/aescm_pkg.sv
src/aescm_if.sv
src/aescm_round.sv
src/aes128_cmac_engine_unit.sv
src/aescm_checker.sv
tb/aes128_cmac_engine_unit_tb.sv
